@@ rtl/core/rotate_scale_bilinear_sampler_unit_assert.svh @@
// assertion macros used by the checker of the sampler
`ifndef ROTATE_SCALE_BILINEAR_SAMPLER_UNIT_ASSERT_SVH
`define ROTATE_SCALE_BILINEAR_SAMPLER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet in reset
`define RSB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sampler check failed");

// next-cycle implication, clocked on clk, quiet in reset
`define RSB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sampler check failed");

`endif

@@ rtl/core/rsb_pkg.sv @@
`timescale 1ns / 1ps
package rsb_pkg;
	localparam int MAX_SPRITE_W = 64;
	localparam int MAX_SPRITE_H = 64;
	localparam int SCREEN_ROWS  = 480;
	localparam int SCREEN_COLS  = 640;
	localparam int STORE_DEPTH  = 4096;
	localparam int STORE_AW     = $clog2(STORE_DEPTH);
	localparam int TEXEL_W      = 32;

	localparam logic        CMD_LOAD   = 1'b0;
	localparam logic        CMD_SAMPLE = 1'b1;

	localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd1;
	localparam logic [2:0] REG_INV_SCALE_X   = 3'd2;
	localparam logic [2:0] REG_INV_SCALE_Y   = 3'd3;
	localparam logic [2:0] REG_COS_ANGLE     = 3'd4;
	localparam logic [2:0] REG_SIN_ANGLE     = 3'd5;
	localparam logic [2:0] REG_ORIGIN_X      = 3'd6;
	localparam logic [2:0] REG_ORIGIN_Y      = 3'd7;

	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
	localparam logic [15:0]        ONE_Q8  = 16'd256;

	// per-item sideband carried down the pipeline
	typedef struct packed {
		logic        cmd;
		logic [15:0] scol;
		logic [15:0] srow;
		logic        row_ok;
	} meta_t;
endpackage

@@ rtl/core/rsb_in_if.sv @@
`timescale 1ns / 1ps
interface rsb_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [11:0] texel_index;
	logic [31:0] texel_argb;
	logic [7:0]  out_col;
	logic [7:0]  out_row;
	modport source (output valid, cmd, texel_index, texel_argb, out_col, out_row, input ready);
	modport sink   (input valid, cmd, texel_index, texel_argb, out_col, out_row, output ready);
endinterface

@@ rtl/core/rsb_out_if.sv @@
`timescale 1ns / 1ps
interface rsb_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] screen_col;
	logic signed [15:0] screen_row;
	logic [31:0]        pixel_argb;
	logic               write_pixel;
	modport source (output valid, screen_col, screen_row, pixel_argb, write_pixel, input ready);
	modport sink   (input valid, screen_col, screen_row, pixel_argb, write_pixel, output ready);
endinterface

@@ rtl/core/rotate_scale_bilinear_sampler_unit.sv @@
`timescale 1ns / 1ps
// a sample passes through the stage registers and then the result register before it is offered at the output
// throughput: one item per cycle while the result register is not held, loads and samples mixed freely
// the rate is set by the texel store: two copies, each read at two addresses per cycle
// a stalled output freezes the whole pipeline, ram read registers included
// reset (arst_n low, asynchronous) clears the pipeline valids and loads the register defaults;
// the texel store is not cleared and holds nothing defined until loaded
module rotate_scale_bilinear_sampler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	rsb_in_if.sink      in_ch,
	rsb_out_if.source   out_ch
);
	// configuration registers
	logic [6:0]         width_q, height_q;
	logic [15:0]        isx_q, isy_q;
	logic signed [15:0] cos_q, sin_q, ox_q, oy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'(rsb_pkg::MAX_SPRITE_W);
			height_q <= 7'(rsb_pkg::MAX_SPRITE_H);
			isx_q    <= rsb_pkg::ONE_Q8;
			isy_q    <= rsb_pkg::ONE_Q8;
			cos_q    <= rsb_pkg::ONE_Q14;
			sin_q    <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rsb_pkg::REG_SPRITE_WIDTH:  width_q  <= cfg_wdata[6:0];
				rsb_pkg::REG_SPRITE_HEIGHT: height_q <= cfg_wdata[6:0];
				rsb_pkg::REG_INV_SCALE_X:   isx_q    <= cfg_wdata;
				rsb_pkg::REG_INV_SCALE_Y:   isy_q    <= cfg_wdata;
				rsb_pkg::REG_COS_ANGLE:     cos_q    <= cfg_wdata;
				rsb_pkg::REG_SIN_ANGLE:     sin_q    <= cfg_wdata;
				rsb_pkg::REG_ORIGIN_X:      ox_q     <= cfg_wdata;
				rsb_pkg::REG_ORIGIN_Y:      oy_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pass-through mode: unit scale, no rotation
	logic ident;
	assign ident = (cos_q == rsb_pkg::ONE_Q14) && (sin_q == '0) &&
		(isx_q == rsb_pkg::ONE_Q8) && (isy_q == rsb_pkg::ONE_Q8);

	// whole pipeline advances together unless the result register is held
	logic en;
	logic v1, v2, v3, v4, v5, v6, v7, v8;
	assign en = !v8 || out_ch.ready;
	assign in_ch.ready = en;

	// stage 1: screen position and scaled offsets from the centre
	logic signed [16:0] scol_c, srow_c;
	logic [23:0]        pu_c, pv_c;
	assign scol_c = {ox_q[15], ox_q} + 17'({9'b0, in_ch.out_col});
	assign srow_c = {oy_q[15], oy_q} + 17'({9'b0, in_ch.out_row});
	assign pu_c   = in_ch.out_col * isx_q;
	assign pv_c   = in_ch.out_row * isy_q;

	rsb_pkg::meta_t     meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6, meta_s7;
	logic signed [25:0] u_s1, v_s1;
	logic [7:0]         col_s1, row_s1, col_s2, row_s2, col_s3, row_s3;
	logic               id_s1, id_s2, id_s3;
	logic               scol_ok_s1, scol_ok_s2, scol_ok_s3;
	logic [11:0]        idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic [31:0]        argb_s1, argb_s2, argb_s3, argb_s4, argb_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1.cmd    <= in_ch.cmd;
			meta_s1.scol   <= scol_c[15:0];
			meta_s1.srow   <= srow_c[15:0];
			meta_s1.row_ok <= !srow_c[16] && (srow_c[15:0] < 16'(rsb_pkg::SCREEN_ROWS));
			scol_ok_s1     <= !scol_c[16] && (scol_c[15:0] < 16'(rsb_pkg::SCREEN_COLS));
			u_s1    <= $signed({2'b0, pu_c}) - $signed(26'({width_q, 7'b0}));
			v_s1    <= $signed({2'b0, pv_c}) - $signed(26'({height_q, 7'b0}));
			col_s1  <= in_ch.out_col;
			row_s1  <= in_ch.out_row;
			id_s1   <= ident;
			idx_s1  <= in_ch.texel_index;
			argb_s1 <= in_ch.texel_argb;
		end
	end

	// stage 2: rotation products
	logic signed [41:0] uc_s2, vs_s2, us_s2, vc_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			uc_s2      <= u_s1 * cos_q;
			vs_s2      <= v_s1 * sin_q;
			us_s2      <= u_s1 * sin_q;
			vc_s2      <= v_s1 * cos_q;
			meta_s2    <= meta_s1;
			scol_ok_s2 <= scol_ok_s1;
			col_s2     <= col_s1;
			row_s2     <= row_s1;
			id_s2      <= id_s1;
			idx_s2     <= idx_s1;
			argb_s2    <= argb_s1;
		end
	end

	// stage 3: sprite coordinates in Q.22, centre added back
	logic signed [43:0] rx_s3, ry_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			rx_s3 <= 44'(uc_s2) - 44'(vs_s2) + $signed({16'b0, width_q, 21'b0});
			ry_s3 <= 44'(us_s2) + 44'(vc_s2) + $signed({16'b0, height_q, 21'b0});
			meta_s3    <= meta_s2;
			scol_ok_s3 <= scol_ok_s2;
			col_s3     <= col_s2;
			row_s3     <= row_s2;
			id_s3      <= id_s2;
			idx_s3     <= idx_s2;
			argb_s3    <= argb_s2;
		end
	end

	// stage 4: floor, fraction and the inside test
	logic rx_in, ry_in, id_in;
	assign rx_in = !rx_s3[43] && (rx_s3[42:29] == '0) && (rx_s3[28:22] < width_q);
	assign ry_in = !ry_s3[43] && (ry_s3[42:29] == '0) && (ry_s3[28:22] < height_q);
	assign id_in = (col_s3 < {1'b0, width_q}) && (row_s3 < {1'b0, height_q}) && scol_ok_s3;

	logic [6:0] tx_s4, ty_s4;
	logic [7:0] fx_s4, fy_s4;
	logic       inside_s4, inside_s5, inside_s6, inside_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			tx_s4     <= id_s3 ? col_s3[6:0] : rx_s3[28:22];
			ty_s4     <= id_s3 ? row_s3[6:0] : ry_s3[28:22];
			fx_s4     <= id_s3 ? 8'd0 : rx_s3[21:14];
			fy_s4     <= id_s3 ? 8'd0 : ry_s3[21:14];
			inside_s4 <= id_s3 ? id_in : (rx_in && ry_in);
			meta_s4   <= meta_s3;
			idx_s4    <= idx_s3;
			argb_s4   <= argb_s3;
		end
	end

	// stage 5: neighbour addresses, edge flags and blend weights
	logic [14:0] base_c;
	logic [8:0]  nfx_c, nfy_c;
	assign base_c = 15'({8'b0, ty_s4} * {8'b0, width_q}) + 15'(tx_s4);
	assign nfx_c  = 9'd256 - 9'(fx_s4);
	assign nfy_c  = 9'd256 - 9'(fy_s4);

	logic [14:0] a00_s5, a10_s5, a01_s5, a11_s5;
	logic        x1_ok_s5, y1_ok_s5;
	logic [16:0] w00_s5, w10_s5, w01_s5, w11_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			a00_s5    <= base_c;
			a10_s5    <= base_c + 15'd1;
			a01_s5    <= base_c + 15'(width_q);
			a11_s5    <= base_c + 15'(width_q) + 15'd1;
			x1_ok_s5  <= ({1'b0, tx_s4} + 8'd1) < {1'b0, width_q};
			y1_ok_s5  <= ({1'b0, ty_s4} + 8'd1) < {1'b0, height_q};
			w00_s5    <= {8'b0, nfx_c} * {8'b0, nfy_c};
			w10_s5    <= {9'b0, fx_s4} * {8'b0, nfy_c};
			w01_s5    <= {8'b0, nfx_c} * {9'b0, fy_s4};
			w11_s5    <= {9'b0, fx_s4} * {9'b0, fy_s4};
			inside_s5 <= inside_s4;
			meta_s5   <= meta_s4;
			idx_s5    <= idx_s4;
			argb_s5   <= argb_s4;
		end
	end

	// texel store: two copies, top row pair and bottom row pair; a load writes at
	// the same stage a sample reads, so program order is kept without forwarding
	logic        st_we;
	logic [31:0] r00, r10, r01, r11;
	assign st_we = en && v5 && (meta_s5.cmd == rsb_pkg::CMD_LOAD);

	rsb_ram #(.WIDTH(rsb_pkg::TEXEL_W), .DEPTH(rsb_pkg::STORE_DEPTH)) u_ram_top (
		.clk   (clk),
		.we    (st_we),
		.waddr (idx_s5),
		.wdata (argb_s5),
		.re    (en),
		.raddr0(a00_s5[rsb_pkg::STORE_AW-1:0]),
		.raddr1(a10_s5[rsb_pkg::STORE_AW-1:0]),
		.rdata0(r00),
		.rdata1(r10)
	);

	rsb_ram #(.WIDTH(rsb_pkg::TEXEL_W), .DEPTH(rsb_pkg::STORE_DEPTH)) u_ram_bot (
		.clk   (clk),
		.we    (st_we),
		.waddr (idx_s5),
		.wdata (argb_s5),
		.re    (en),
		.raddr0(a01_s5[rsb_pkg::STORE_AW-1:0]),
		.raddr1(a11_s5[rsb_pkg::STORE_AW-1:0]),
		.rdata0(r01),
		.rdata1(r11)
	);

	// stage 6 runs alongside the ram read registers
	logic        k00_s6, k10_s6, k01_s6, k11_s6;
	logic [16:0] w00_s6, w10_s6, w01_s6, w11_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			k00_s6    <= a00_s5 < 15'(rsb_pkg::STORE_DEPTH);
			k10_s6    <= x1_ok_s5 && (a10_s5 < 15'(rsb_pkg::STORE_DEPTH));
			k01_s6    <= y1_ok_s5 && (a01_s5 < 15'(rsb_pkg::STORE_DEPTH));
			k11_s6    <= x1_ok_s5 && y1_ok_s5 && (a11_s5 < 15'(rsb_pkg::STORE_DEPTH));
			w00_s6    <= w00_s5;
			w10_s6    <= w10_s5;
			w01_s6    <= w01_s5;
			w11_s6    <= w11_s5;
			inside_s6 <= inside_s5;
			meta_s6   <= meta_s5;
		end
	end

	// texels past the sprite edge or beyond the store read as zero
	logic [31:0] c00, c10, c01, c11;
	assign c00 = k00_s6 ? r00 : '0;
	assign c10 = k10_s6 ? r10 : '0;
	assign c01 = k01_s6 ? r01 : '0;
	assign c11 = k11_s6 ? r11 : '0;

	// stage 7: weighted channel products, one lane per byte
	logic [23:0] p00_s7 [4], p10_s7 [4], p01_s7 [4], p11_s7 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int ch = 0; ch < 4; ch++) begin
				p00_s7[ch] <= {7'b0, w00_s6} * {16'b0, c00[ch*8 +: 8]};
				p10_s7[ch] <= {7'b0, w10_s6} * {16'b0, c10[ch*8 +: 8]};
				p01_s7[ch] <= {7'b0, w01_s6} * {16'b0, c01[ch*8 +: 8]};
				p11_s7[ch] <= {7'b0, w11_s6} * {16'b0, c11[ch*8 +: 8]};
			end
			inside_s7 <= inside_s6;
			meta_s7   <= meta_s6;
		end
	end

	// stage 8: lane sums, truncation and the write flag
	logic [31:0] pix_c;
	logic        wr_c;
	always_comb begin
		logic [23:0] acc;
		pix_c = '0;
		for (int ch = 0; ch < 4; ch++) begin
			acc = p00_s7[ch] + p10_s7[ch] + p01_s7[ch] + p11_s7[ch];
			pix_c[ch*8 +: 8] = acc[23:16];
		end
	end
	assign wr_c = inside_s7 && meta_s7.row_ok && (pix_c[31:24] != '0);

	logic signed [15:0] scol_q, srow_q;
	logic [31:0]        pix_q;
	logic               wr_q;
	always_ff @(posedge clk) begin
		if (en) begin
			scol_q <= meta_s7.scol;
			srow_q <= meta_s7.srow;
			pix_q  <= wr_c ? pix_c : '0;
			wr_q   <= wr_c;
		end
	end

	// valid chain; a load drops out after its store write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v1, v2, v3, v4, v5, v6, v7, v8} <= '0;
		end else if (en) begin
			v1 <= in_ch.valid;
			v2 <= v1;
			v3 <= v2;
			v4 <= v3;
			v5 <= v4;
			v6 <= v5 && (meta_s5.cmd == rsb_pkg::CMD_SAMPLE);
			v7 <= v6;
			v8 <= v7;
		end
	end

	assign out_ch.valid       = v8;
	assign out_ch.screen_col  = scol_q;
	assign out_ch.screen_row  = srow_q;
	assign out_ch.pixel_argb  = pix_q;
	assign out_ch.write_pixel = wr_q;
endmodule

@@ rtl/core/rsb_ram.sv @@
`timescale 1ns / 1ps
module rsb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end
endmodule

@@ rtl/core/rsb_checker.sv @@
`timescale 1ns / 1ps
`include "rotate_scale_bilinear_sampler_unit_assert.svh"
module rsb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] pixel_argb,
	input logic        write_pixel
);
	// a held result stays offered
	`RSB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// a written pixel is never transparent
	`RSB_ASSERT_NOW(a_wr_alpha, out_valid && write_pixel, pixel_argb[31:24] != 8'd0)
	// a dropped pixel carries no colour
	`RSB_ASSERT_NOW(a_drop_zero, out_valid && !write_pixel, pixel_argb == 32'd0)
	// with the result register empty the input is always open
	`RSB_ASSERT_NOW(a_ready_free, !out_valid, in_ready)
endmodule

bind rotate_scale_bilinear_sampler_unit rsb_checker u_rsb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.pixel_argb (out_ch.pixel_argb),
	.write_pixel(out_ch.write_pixel)
);
